>>> design/kct_pkg.sv
// Shared types, sizes and codes for the keyed context table.
`default_nettype none

package kct_pkg;

    // Table geometry
    localparam int ENTRY_COUNT = 256;
    localparam int SLOT_COUNT  = 8;

    localparam int IDX_W   = $clog2(ENTRY_COUNT);
    localparam int CNT_W   = IDX_W + 1;
    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int VDEPTH  = ENTRY_COUNT * SLOT_COUNT;
    localparam int VADDR_W = $clog2(VDEPTH);

    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int SLOTF_W  = 8;
    localparam int STATUS_W = 3;

    localparam logic [SLOTF_W-1:0] SLOT_LIMIT = SLOTF_W'(SLOT_COUNT);
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0]   ENTRY_MAX  = CNT_W'(ENTRY_COUNT);

    // Operation codes; the two spare codes act as find
    localparam logic [OP_W-1:0] OP_SAVE   = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_KEY  = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_CLEAR,
        ST_FETCH,
        ST_DONE
    } state_t;

    // One request as taken from the input beat
    typedef struct packed {
        logic [VAL_W-1:0]   value_in;
        logic [SLOTF_W-1:0] slot_index;
        logic [KEY_W-1:0]   resource_key;
        logic [OP_W-1:0]    op;
    } req_t;

    // One result handed to the output stage
    typedef struct packed {
        logic [VAL_W-1:0]    value_out;
        logic [STATUS_W-1:0] status;
    } res_t;

    // Write port of the key memory
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] data;
    } key_wr_t;

    // Write port of the value memory
    typedef struct packed {
        logic               we;
        logic [VADDR_W-1:0] addr;
        logic [VAL_W-1:0]   data;
    } val_wr_t;

    // Flat value memory address of one slot of one entry
    function automatic logic [VADDR_W-1:0] val_addr(input logic [IDX_W-1:0] ent,
                                                    input logic [SLOT_W-1:0] slot);
        return VADDR_W'(ent) * VADDR_W'(SLOT_COUNT) + VADDR_W'(slot);
    endfunction

endpackage

`default_nettype wire

>>> design/kct_ram.sv
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module kct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/kct_ctrl.sv
// Sequencer: linear key scan with one shared comparator, then slot update.
`default_nettype none

module kct_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire kct_pkg::req_t               req,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output kct_pkg::res_t                    res,
    output logic [kct_pkg::IDX_W-1:0]        key_raddr,
    input  wire logic [kct_pkg::KEY_W-1:0]   key_rdata,
    output kct_pkg::key_wr_t                 key_wr,
    output logic [kct_pkg::VADDR_W-1:0]      val_raddr,
    input  wire logic [kct_pkg::VAL_W-1:0]   val_rdata,
    output kct_pkg::val_wr_t                 val_wr
);

    kct_pkg::state_t state_reg, state_next;

    logic [kct_pkg::OP_W-1:0]     op_reg, op_next;
    logic [kct_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [kct_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [kct_pkg::VAL_W-1:0]    val_reg, val_next;
    logic [kct_pkg::CNT_W-1:0]    scan_reg, scan_next;
    logic                         pend_reg, pend_next;
    logic [kct_pkg::IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                         found_reg, found_next;
    logic [kct_pkg::IDX_W-1:0]    ent_reg, ent_next;
    logic                         free_vld_reg, free_vld_next;
    logic [kct_pkg::IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [kct_pkg::CNT_W-1:0]    used_reg, used_next;
    logic [kct_pkg::SLOT_W-1:0]   clr_reg, clr_next;
    logic [kct_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [kct_pkg::VAL_W-1:0]    value_reg, value_next;

    logic                        issue;
    logic                        hit;
    logic                        free_hit;
    logic                        scan_end;
    logic                        has_room;
    logic [kct_pkg::SLOT_W-1:0]  slot_sel;
    logic [kct_pkg::IDX_W-1:0]   new_ent;

    // Shared key comparator on the previous cycle's read
    assign issue    = (scan_reg < used_reg);
    assign hit      = pend_reg && (key_rdata == key_reg);
    assign free_hit = pend_reg && (key_rdata == '0);
    assign scan_end = !issue && !pend_reg;
    assign has_room = (used_reg < kct_pkg::ENTRY_MAX);
    assign slot_sel = slot_reg;
    assign new_ent  = free_vld_reg ? free_idx_reg : used_reg[kct_pkg::IDX_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kct_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.resource_key == '0 || req.slot_index >= kct_pkg::SLOT_LIMIT)
                    begin
                        state_next = kct_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = kct_pkg::ST_SEARCH;
                    end
                end
            end
            kct_pkg::ST_SEARCH:
            begin
                if (hit || scan_end)
                begin
                    state_next = kct_pkg::ST_DECIDE;
                end
            end
            kct_pkg::ST_DECIDE:
            begin
                unique case (op_reg)
                    kct_pkg::OP_SAVE:
                    begin
                        if (!found_reg && (free_vld_reg || has_room))
                        begin
                            state_next = kct_pkg::ST_CLEAR;
                        end
                        else
                        begin
                            state_next = kct_pkg::ST_DONE;
                        end
                    end
                    kct_pkg::OP_DELETE:
                    begin
                        state_next = kct_pkg::ST_DONE;
                    end
                    default:
                    begin
                        state_next = found_reg ? kct_pkg::ST_FETCH : kct_pkg::ST_DONE;
                    end
                endcase
            end
            kct_pkg::ST_CLEAR:
            begin
                if (clr_reg == kct_pkg::LAST_SLOT)
                begin
                    state_next = kct_pkg::ST_DONE;
                end
            end
            kct_pkg::ST_FETCH:
            begin
                state_next = kct_pkg::ST_DONE;
            end
            kct_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = kct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kct_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory port outputs
    always_comb
    begin
        op_next       = op_reg;
        key_next      = key_reg;
        slot_next     = slot_reg;
        val_next      = val_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        ent_next      = ent_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        used_next     = used_reg;
        clr_next      = clr_reg;
        status_next   = status_reg;
        value_next    = value_reg;
        key_wr        = '0;
        val_wr        = '0;
        req_ready     = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            kct_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next       = req.op;
                    key_next      = req.resource_key;
                    slot_next     = req.slot_index[kct_pkg::SLOT_W-1:0];
                    val_next      = req.value_in;
                    scan_next     = '0;
                    pend_next     = 1'b0;
                    found_next    = 1'b0;
                    free_vld_next = 1'b0;
                    clr_next      = '0;
                    value_next    = '0;
                    status_next   = kct_pkg::STATUS_OK;
                    if (req.resource_key == '0)
                    begin
                        status_next = kct_pkg::STATUS_ZERO_KEY;
                    end
                    else if (req.slot_index >= kct_pkg::SLOT_LIMIT)
                    begin
                        status_next = kct_pkg::STATUS_BAD_SLOT;
                    end
                end
            end
            kct_pkg::ST_SEARCH:
            begin
                // Issue one key read per cycle, compare it the cycle after
                pend_next     = issue && !hit;
                pend_idx_next = scan_reg[kct_pkg::IDX_W-1:0];
                if (issue)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (hit)
                begin
                    found_next = 1'b1;
                    ent_next   = pend_idx_reg;
                end
                else if (free_hit && !free_vld_reg)
                begin
                    free_vld_next = 1'b1;
                    free_idx_next = pend_idx_reg;
                end
            end
            kct_pkg::ST_DECIDE:
            begin
                unique case (op_reg)
                    kct_pkg::OP_SAVE:
                    begin
                        if (found_reg)
                        begin
                            val_wr.we   = 1'b1;
                            val_wr.addr = kct_pkg::val_addr(ent_reg, slot_sel);
                            val_wr.data = val_reg;
                        end
                        else if (free_vld_reg || has_room)
                        begin
                            // Claim a freed entry or append one
                            key_wr.we   = 1'b1;
                            key_wr.addr = new_ent;
                            key_wr.data = key_reg;
                            ent_next    = new_ent;
                            if (!free_vld_reg)
                            begin
                                used_next = used_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            status_next = kct_pkg::STATUS_FULL;
                        end
                    end
                    kct_pkg::OP_DELETE:
                    begin
                        if (found_reg)
                        begin
                            val_wr.we   = 1'b1;
                            val_wr.addr = kct_pkg::val_addr(ent_reg, slot_sel);
                            key_wr.we   = 1'b1;
                            key_wr.addr = ent_reg;
                        end
                        else
                        begin
                            status_next = kct_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        if (!found_reg)
                        begin
                            status_next = kct_pkg::STATUS_NOT_FOUND;
                        end
                    end
                endcase
            end
            kct_pkg::ST_CLEAR:
            begin
                // Sweep the new entry's slots, placing the saved value on the way
                val_wr.we   = 1'b1;
                val_wr.addr = kct_pkg::val_addr(ent_reg, clr_reg);
                val_wr.data = (clr_reg == slot_sel) ? val_reg : '0;
                clr_next    = clr_reg + 1'b1;
            end
            kct_pkg::ST_FETCH:
            begin
                value_next = val_rdata;
                if (val_rdata == '0)
                begin
                    status_next = kct_pkg::STATUS_NOT_FOUND;
                end
            end
            kct_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign key_raddr     = scan_reg[kct_pkg::IDX_W-1:0];
    assign val_raddr     = kct_pkg::val_addr(ent_reg, slot_sel);
    assign res.status    = status_reg;
    assign res.value_out = value_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kct_pkg::ST_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        slot_reg     <= slot_next;
        val_reg      <= val_next;
        scan_reg     <= scan_next;
        pend_reg     <= pend_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        ent_reg      <= ent_next;
        free_vld_reg <= free_vld_next;
        free_idx_reg <= free_idx_next;
        clr_reg      <= clr_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
    end

endmodule

`default_nettype wire

>>> design/keyed_context_table.sv
// Top level of the keyed context table: memories, sequencer and output stage.
//
// Each input beat is a save, delete or find on a table of up to ENTRY_COUNT
// resource keys, each owning SLOT_COUNT 32-bit context slots, and gives one
// output beat with a status and, for a successful find, the slot's value.
// The block takes one beat at a time. A beat with a zero key or a slot index
// out of range is answered without a scan. Otherwise the key memory's single
// read port is walked over the entries ever taken (at most ENTRY_COUNT), one
// entry per cycle, until the key matches; a save that claims a new entry then
// clears its slots through the value memory's write port, and a find that hits
// reads the value. The table starts empty after reset with no clearing pass.
// The output beat is registered, so a new item may be taken while a finished
// result waits to be read.
`default_nettype none

module keyed_context_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] op, [33:2] resource_key, [41:34] slot_index, [73:42] value_in, [79:74] zero
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] status, [34:3] value_out, [39:35] zero
    output logic [39:0]      m_axis_tdata
);

    kct_pkg::req_t    req;
    kct_pkg::res_t    res;
    logic             res_valid;
    logic             res_ready;

    logic [kct_pkg::IDX_W-1:0]   key_raddr;
    logic [kct_pkg::KEY_W-1:0]   key_rdata;
    kct_pkg::key_wr_t            key_wr;
    logic [kct_pkg::VADDR_W-1:0] val_raddr;
    logic [kct_pkg::VAL_W-1:0]   val_rdata;
    kct_pkg::val_wr_t            val_wr;

    logic          out_vld_reg, out_vld_next;
    kct_pkg::res_t out_res_reg, out_res_next;

    // Unpack the input beat
    assign req.op           = s_axis_tdata[1:0];
    assign req.resource_key = s_axis_tdata[33:2];
    assign req.slot_index   = s_axis_tdata[41:34];
    assign req.value_in     = s_axis_tdata[73:42];

    kct_ram #(
        .WIDTH (kct_pkg::KEY_W),
        .DEPTH (kct_pkg::ENTRY_COUNT)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_wr.we),
        .waddr (key_wr.addr),
        .wdata (key_wr.data),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kct_ram #(
        .WIDTH (kct_pkg::VAL_W),
        .DEPTH (kct_pkg::VDEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_wr.we),
        .waddr (val_wr.addr),
        .wdata (val_wr.data),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    kct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .key_raddr (key_raddr),
        .key_rdata (key_rdata),
        .key_wr    (key_wr),
        .val_raddr (val_raddr),
        .val_rdata (val_rdata),
        .val_wr    (val_wr)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        if (res_ready)
        begin
            out_vld_next = res_valid;
            if (res_valid)
            begin
                out_res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'd0, out_res_reg.value_out, out_res_reg.status};

endmodule

`default_nettype wire

>>> design/kct_checker.sv
// Port-level checks for the keyed context table, bound to the top level.
`default_nettype none

module kct_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    // A stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // One item at a time: no input taken right after an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // Status codes stay within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == kct_pkg::STATUS_OK ||
                           m_axis_tdata[2:0] == kct_pkg::STATUS_NOT_FOUND ||
                           m_axis_tdata[2:0] == kct_pkg::STATUS_BAD_SLOT ||
                           m_axis_tdata[2:0] == kct_pkg::STATUS_FULL ||
                           m_axis_tdata[2:0] == kct_pkg::STATUS_ZERO_KEY))
        else $error("undefined status code");

    // A value is only returned with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != kct_pkg::STATUS_OK) |->
            (m_axis_tdata[34:3] == '0))
        else $error("value returned with a failing status");

endmodule

bind keyed_context_table kct_checker u_kct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
